### hw/rtl/foot_contact_and_center_of_pressure_defines.svh
// ----------------------------------------------------------------------------
// foot contact and center of pressure: assertion macros
// Wraps concurrent checks on clk with an asynchronous active-low reset.
// Synthesis builds define SYNTH and get empty bodies.
// ----------------------------------------------------------------------------
`ifndef FOOT_CONTACT_AND_CENTER_OF_PRESSURE_DEFINES_SVH
`define FOOT_CONTACT_AND_CENTER_OF_PRESSURE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define FCCP_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fccp: same-cycle check failed");

// next-cycle implication
`define FCCP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fccp: next-cycle check failed");

`else

`define FCCP_ASSERT_IMPLY(lbl, pre, post)
`define FCCP_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

### hw/rtl/fccp_pkg.sv
// ----------------------------------------------------------------------------
// fccp_pkg
// Shared types, widths, register indexes and sensor position tables.
// ----------------------------------------------------------------------------
`default_nettype none

package fccp_pkg;

    localparam int LOAD_W             = 16;
    localparam int FSUM_W             = 18;   // sum of four loads
    localparam int POS_W              = 12;   // sensor position, 1/16 mm
    localparam int COORD_W            = 12;
    localparam int PROD_W             = 29;
    localparam int ACC_W              = 30;
    localparam int QUO_W              = 11;   // quotient magnitude stays below 2048
    localparam int NUM_W              = 31;
    localparam int REM_W              = NUM_W - QUO_W;
    localparam int DIV_W              = FSUM_W + 1;
    localparam int CNT_W              = 4;
    localparam int MAC_STEPS          = 8;    // four sensors times two axes
    localparam int OFFSET_W           = 17;
    localparam int MASS_W             = 16;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 17;
    localparam int DEF_AVERAGE_LENGTH = 16;

    localparam logic [MASS_W-1:0] MASS_RESET = 16'd5335;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_MASS    = 1'b1;

    typedef struct packed {
        logic [LOAD_W-1:0] left_back_left;
        logic [LOAD_W-1:0] left_back_right;
        logic [LOAD_W-1:0] left_front_left;
        logic [LOAD_W-1:0] left_front_right;
        logic [LOAD_W-1:0] right_back_left;
        logic [LOAD_W-1:0] right_back_right;
        logic [LOAD_W-1:0] right_front_left;
        logic [LOAD_W-1:0] right_front_right;
    } frame_t;

    typedef struct packed {
        logic                      left_contact;
        logic                      right_contact;
        logic signed [COORD_W-1:0] pressure_x;
        logic signed [COORD_W-1:0] pressure_y;
        logic                      pressure_updated;
    } result_t;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_CLEAR    = 3'd1,
        OP_MAC      = 3'd2,
        OP_DIV_LOAD = 3'd3,
        OP_DIV_STEP = 3'd4
    } unit_op_t;

    typedef struct packed {
        unit_op_t                op;
        logic                    coord;     // 0: x, 1: y
        logic [LOAD_W-1:0]       load;
        logic signed [POS_W-1:0] pos;
        logic [FSUM_W-1:0]       divisor;
    } unit_req_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } win_req_t;

    // sensor order: back left, back right, front left, front right
    function automatic logic signed [POS_W-1:0] sensor_x(input logic [1:0] idx);
        logic signed [POS_W-1:0] val;
        unique case (idx)
            2'd0: val = -12'sd484;
            2'd1: val = -12'sd474;
            2'd2: val = 12'sd1124;
            2'd3: val = 12'sd1124;
        endcase
        return val;
    endfunction

    function automatic logic signed [POS_W-1:0] sensor_y(input logic foot,
                                                         input logic [1:0] idx);
        logic signed [POS_W-1:0] val;
        unique case ({foot, idx})
            3'b000: val = 12'sd478;
            3'b001: val = -12'sd306;
            3'b010: val = 12'sd478;
            3'b011: val = -12'sd370;
            3'b100: val = 12'sd306;
            3'b101: val = -12'sd478;
            3'b110: val = 12'sd370;
            3'b111: val = -12'sd478;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fccp_window.sv
// ----------------------------------------------------------------------------
// fccp_window
// Moving-average windows for both feet: one memory, running sums, fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module fccp_window #(
    parameter int AVERAGE_LENGTH = fccp_pkg::DEF_AVERAGE_LENGTH
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  fccp_pkg::win_req_t                                       req,
    input  logic [fccp_pkg::FSUM_W-1:0]                              left_load,
    input  logic [fccp_pkg::FSUM_W-1:0]                              right_load,
    output logic                                                     full,
    output logic [fccp_pkg::FSUM_W+$clog2(AVERAGE_LENGTH)-1:0]       left_sum,
    output logic [fccp_pkg::FSUM_W+$clog2(AVERAGE_LENGTH)-1:0]       right_sum
);
    import fccp_pkg::*;

    localparam int SUM_W  = FSUM_W + $clog2(AVERAGE_LENGTH);
    localparam int WPOS_W = $clog2(AVERAGE_LENGTH);
    localparam int FILL_W = $clog2(AVERAGE_LENGTH + 1);
    localparam logic [WPOS_W-1:0] LAST_POS = WPOS_W'(AVERAGE_LENGTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(AVERAGE_LENGTH);

    logic [2*FSUM_W-1:0] mem [AVERAGE_LENGTH];
    logic [2*FSUM_W-1:0] rd_data_reg;

    logic [WPOS_W-1:0] pos_reg;
    logic [WPOS_W-1:0] pos_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [SUM_W-1:0]  left_sum_reg;
    logic [SUM_W-1:0]  left_sum_next;
    logic [SUM_W-1:0]  right_sum_reg;
    logic [SUM_W-1:0]  right_sum_next;
    logic [FSUM_W-1:0] left_old;
    logic [FSUM_W-1:0] right_old;
    logic              full_now;

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            rd_data_reg <= mem[pos_reg];
        end
        if (req.wr)
        begin
            mem[pos_reg] <= {left_load, right_load};
        end
    end

    // until the window is full the entry at the write position was never written
    assign full_now  = (fill_reg == FILL_MAX);
    assign left_old  = full_now ? rd_data_reg[2*FSUM_W-1:FSUM_W] : '0;
    assign right_old = full_now ? rd_data_reg[FSUM_W-1:0] : '0;

    always_comb
    begin
        left_sum_next  = left_sum_reg - SUM_W'(left_old) + SUM_W'(left_load);
        right_sum_next = right_sum_reg - SUM_W'(right_old) + SUM_W'(right_load);
        pos_next       = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        fill_next      = full_now ? fill_reg : fill_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
        end
        else if (req.wr)
        begin
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            left_sum_reg  <= left_sum_next;
            right_sum_reg <= right_sum_next;
        end
    end

    assign full      = full_now;
    assign left_sum  = left_sum_reg;
    assign right_sum = right_sum_reg;

endmodule

`default_nettype wire

### hw/rtl/fccp_unit.sv
// ----------------------------------------------------------------------------
// fccp_unit
// Shared arithmetic: weighted-load accumulation and a restoring divider that
// yields one quotient bit per step, rounded to nearest, ties away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fccp_unit (
    input  logic                                   clk,
    input  fccp_pkg::unit_req_t                    req,
    output logic signed [fccp_pkg::COORD_W-1:0]    quotient
);
    import fccp_pkg::*;

    logic signed [ACC_W-1:0]   acc_x_reg;
    logic signed [ACC_W-1:0]   acc_y_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [REM_W-1:0]          rem_next;
    logic [QUO_W-1:0]          quo_reg;
    logic [DIV_W-1:0]          div_reg;
    logic                      neg_reg;

    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_sel;
    logic signed [ACC_W-1:0]   acc_abs;
    logic [NUM_W-1:0]          num;
    logic [REM_W:0]            trial;
    logic [REM_W:0]            div_ext;
    logic [REM_W:0]            diff;
    logic                      ge;
    logic signed [COORD_W-1:0] quo_ext;

    assign prod     = req.pos * $signed({1'b0, req.load});
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    assign acc_sel  = req.coord ? acc_y_reg : acc_x_reg;
    assign acc_abs  = acc_sel[ACC_W-1] ? -acc_sel : acc_sel;

    // rounded quotient of |s| / d is floor((2|s| + d) / 2d)
    assign num = {1'b0, acc_abs[ACC_W-2:0], 1'b0} + {{(NUM_W-FSUM_W){1'b0}}, req.divisor};

    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign div_ext  = {{(REM_W+1-DIV_W){1'b0}}, div_reg};
    assign ge       = (trial >= div_ext);
    assign diff     = trial - div_ext;
    assign rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

    always_ff @(posedge clk)
    begin
        unique case (req.op)
            OP_NONE:
            begin
            end
            OP_CLEAR:
            begin
                acc_x_reg <= '0;
                acc_y_reg <= '0;
            end
            OP_MAC:
            begin
                if (req.coord)
                begin
                    acc_y_reg <= acc_y_reg + prod_ext;
                end
                else
                begin
                    acc_x_reg <= acc_x_reg + prod_ext;
                end
            end
            OP_DIV_LOAD:
            begin
                rem_reg <= num[NUM_W-1:QUO_W];
                quo_reg <= num[QUO_W-1:0];
                div_reg <= {req.divisor, 1'b0};
                neg_reg <= acc_sel[ACC_W-1];
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

    assign quo_ext  = {{(COORD_W-QUO_W){1'b0}}, quo_reg};
    assign quotient = neg_reg ? -quo_ext : quo_ext;

endmodule

`default_nettype wire

### hw/rtl/foot_contact_and_center_of_pressure.sv
// ----------------------------------------------------------------------------
// foot_contact_and_center_of_pressure
// Foot contact detection and single-support center of pressure estimation.
// ----------------------------------------------------------------------------
// Takes one frame of eight foot loads per request and returns one result per
// frame. A frame that recomputes the center of pressure runs the MAC and
// divide states, one that does not goes from the contact check to output.
// frame_ready comes back at the same edge that loads the result into the
// output register, which waits until an earlier result is taken; the next
// frame is taken in the cycle after at the earliest. The long path is set
// by the shared unit: eight multiply-accumulate steps through one
// multiplier, then two restoring divisions of eleven one-bit steps each,
// x before y. The window memory holds AVERAGE_LENGTH entries per foot and
// needs no clearing pass: a fill count marks entries not yet written.
`default_nettype none

`include "foot_contact_and_center_of_pressure_defines.svh"

module foot_contact_and_center_of_pressure #(
    parameter int AVERAGE_LENGTH = fccp_pkg::DEF_AVERAGE_LENGTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fccp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fccp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                frame_valid,
    output logic                                frame_ready,
    input  fccp_pkg::frame_t                    frame,
    output logic                                result_valid,
    input  logic                                result_ready,
    output fccp_pkg::result_t                   result
);
    import fccp_pkg::*;

    localparam int SUM_W = FSUM_W + $clog2(AVERAGE_LENGTH);
    localparam int CMP_W = 20 + $clog2(AVERAGE_LENGTH + 1);
    localparam logic signed [CMP_W-1:0] LEN_S = CMP_W'(AVERAGE_LENGTH);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_READ     = 9'b000000010,
        S_UPDATE   = 9'b000000100,
        S_CONTACT  = 9'b000001000,
        S_MAC      = 9'b000010000,
        S_DIV_LOAD = 9'b000100000,
        S_DIV_STEP = 9'b001000000,
        S_DIV_DONE = 9'b010000000,
        S_OUT      = 9'b100000000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;

    logic signed [OFFSET_W-1:0] weight_offset_reg;
    logic [MASS_W-1:0]          total_mass_reg;

    frame_t                    frame_reg;
    logic [FSUM_W-1:0]         lsum_reg;
    logic [FSUM_W-1:0]         rsum_reg;
    logic [FSUM_W-1:0]         dsum_reg;
    logic signed [CMP_W-1:0]   thr_reg;
    logic                      lc_reg;
    logic                      rc_reg;
    logic                      upd_reg;
    logic                      foot_reg;
    logic                      coord_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [COORD_W-1:0] last_x_reg;
    logic signed [COORD_W-1:0] last_y_reg;
    result_t                   result_reg;
    logic                      result_valid_reg;

    win_req_t                  win_req;
    logic                      win_full;
    logic [SUM_W-1:0]          left_sum;
    logic [SUM_W-1:0]          right_sum;
    unit_req_t                 unit_req;
    logic signed [COORD_W-1:0] unit_quotient;

    logic [FSUM_W-1:0]         lsum_next;
    logic [FSUM_W-1:0]         rsum_next;
    logic signed [OFFSET_W:0]  diff_mass;
    logic signed [CMP_W-1:0]   thr_next;
    logic signed [CMP_W-1:0]   left_margin;
    logic signed [CMP_W-1:0]   right_margin;
    logic                      lc_next;
    logic                      rc_next;
    logic                      single;
    logic [FSUM_W-1:0]         dsum_next;
    logic [LOAD_W-1:0]         mac_load;
    logic                      out_free;

    fccp_window #(
        .AVERAGE_LENGTH (AVERAGE_LENGTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (win_req),
        .left_load  (lsum_reg),
        .right_load (rsum_reg),
        .full       (win_full),
        .left_sum   (left_sum),
        .right_sum  (right_sum)
    );

    fccp_unit u_unit (
        .clk      (clk),
        .req      (unit_req),
        .quotient (unit_quotient)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_offset_reg <= '0;
            total_mass_reg    <= MASS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WEIGHT_OFFSET: weight_offset_reg <= $signed(cfg_data[OFFSET_W-1:0]);
                CFG_TOTAL_MASS:    total_mass_reg    <= cfg_data[MASS_W-1:0];
            endcase
        end
    end

    assign lsum_next = {2'b00, frame_reg.left_back_left} + {2'b00, frame_reg.left_back_right}
                     + {2'b00, frame_reg.left_front_left} + {2'b00, frame_reg.left_front_right};
    assign rsum_next = {2'b00, frame_reg.right_back_left} + {2'b00, frame_reg.right_back_right}
                     + {2'b00, frame_reg.right_front_left}
                     + {2'b00, frame_reg.right_front_right};

    // contact when the window is full and sum + (offset - mass) * length >= 0
    assign diff_mass = {weight_offset_reg[OFFSET_W-1], weight_offset_reg}
                     - $signed({2'b00, total_mass_reg});
    assign thr_next  = {{(CMP_W-OFFSET_W-1){diff_mass[OFFSET_W]}}, diff_mass} * LEN_S;

    assign left_margin  = $signed({{(CMP_W-SUM_W){1'b0}}, left_sum}) + thr_reg;
    assign right_margin = $signed({{(CMP_W-SUM_W){1'b0}}, right_sum}) + thr_reg;
    assign lc_next      = win_full && !left_margin[CMP_W-1];
    assign rc_next      = win_full && !right_margin[CMP_W-1];
    assign single       = lc_next ^ rc_next;
    assign dsum_next    = lc_next ? lsum_reg : rsum_reg;

    always_comb
    begin
        unique case ({foot_reg, cnt_reg[1:0]})
            3'b000: mac_load = frame_reg.left_back_left;
            3'b001: mac_load = frame_reg.left_back_right;
            3'b010: mac_load = frame_reg.left_front_left;
            3'b011: mac_load = frame_reg.left_front_right;
            3'b100: mac_load = frame_reg.right_back_left;
            3'b101: mac_load = frame_reg.right_back_right;
            3'b110: mac_load = frame_reg.right_front_left;
            3'b111: mac_load = frame_reg.right_front_right;
        endcase
    end

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next       = state_reg;
        win_req          = '0;
        unit_req.op      = OP_NONE;
        unit_req.coord   = coord_reg;
        unit_req.load    = mac_load;
        unit_req.pos     = cnt_reg[2] ? sensor_y(foot_reg, cnt_reg[1:0])
                                      : sensor_x(cnt_reg[1:0]);
        unit_req.divisor = dsum_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                win_req.rd = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                win_req.wr = 1'b1;
                state_next = S_CONTACT;
            end
            S_CONTACT:
            begin
                if (single && (dsum_next != '0))
                begin
                    unit_req.op = OP_CLEAR;
                    state_next  = S_MAC;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MAC:
            begin
                unit_req.op    = OP_MAC;
                unit_req.coord = cnt_reg[2];
                if (cnt_reg == CNT_W'(MAC_STEPS - 1))
                begin
                    state_next = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD:
            begin
                unit_req.op = OP_DIV_LOAD;
                state_next  = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                unit_req.op = OP_DIV_STEP;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    state_next = S_DIV_DONE;
                end
            end
            S_DIV_DONE:
            begin
                state_next = coord_reg ? S_OUT : S_DIV_LOAD;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            lc_reg           <= 1'b0;
            rc_reg           <= 1'b0;
            upd_reg          <= 1'b0;
            foot_reg         <= 1'b0;
            coord_reg        <= 1'b0;
            cnt_reg          <= '0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_CONTACT:
                begin
                    lc_reg    <= lc_next;
                    rc_reg    <= rc_next;
                    upd_reg   <= single && (dsum_next != '0);
                    foot_reg  <= rc_next;
                    coord_reg <= 1'b0;
                    cnt_reg   <= '0;
                end
                S_MAC:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_DIV_LOAD:
                begin
                    cnt_reg <= '0;
                end
                S_DIV_STEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_DIV_DONE:
                begin
                    if (coord_reg)
                    begin
                        last_y_reg <= unit_quotient;
                    end
                    else
                    begin
                        last_x_reg <= unit_quotient;
                    end
                    coord_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
            if ((state_reg == S_OUT) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
        begin
            frame_reg <= frame;
        end
        if (state_reg == S_READ)
        begin
            lsum_reg <= lsum_next;
            rsum_reg <= rsum_next;
            thr_reg  <= thr_next;
        end
        if (state_reg == S_CONTACT)
        begin
            dsum_reg <= dsum_next;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            result_reg.left_contact     <= lc_reg;
            result_reg.right_contact    <= rc_reg;
            result_reg.pressure_x       <= last_x_reg;
            result_reg.pressure_y       <= last_y_reg;
            result_reg.pressure_updated <= upd_reg;
        end
    end

    assign frame_ready  = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `FCCP_ASSERT_IMPLY(a_upd_single_foot, result_valid_reg && result_reg.pressure_updated, result_reg.left_contact != result_reg.right_contact)
    `FCCP_ASSERT_IMPLY(a_div_step_bound, state_reg == S_DIV_STEP, cnt_reg < CNT_W'(QUO_W))
    `FCCP_ASSERT_NEXT(a_out_loads_result, (state_reg == S_OUT) && out_free, result_valid_reg && frame_ready)
    `FCCP_ASSERT_NEXT(a_busy_after_accept, frame_valid && frame_ready, !frame_ready)

endmodule

`default_nettype wire

### verif/foot_contact_and_center_of_pressure_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// foot_contact_and_center_of_pressure_tb
// Drives sensor frames through the valid/ready request channel and checks
// every result: typed rows of a short table against fixed values, all
// other frames against a cycle-free model of the contact windows and the
// center of pressure. The table comes first. Random phases follow, each
// with its own offset and mass setting. Most random frames come in gait
// runs (left stance, right stance, double support, swing); the rest are noise.
// ----------------------------------------------------------------------------

module foot_contact_and_center_of_pressure_tb;

    import fccp_pkg::*;

    localparam int WIN_LEN       = DEF_AVERAGE_LENGTH;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DIRECTED_ROWS = 22;
    localparam int PHASE_ITEMS   = 110;
    localparam int PHASES        = 6;

    localparam result_t QUIET = '0;

    typedef enum int {
        GAIT_LEFT,
        GAIT_RIGHT,
        GAIT_DOUBLE,
        GAIT_SWING,
        GAIT_NOISE
    } gait_t;

    typedef enum int {
        LOAD_LIGHT,
        LOAD_HEAVY,
        LOAD_NOISE
    } load_kind_t;

    typedef struct packed {
        frame_t  f;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  frame_valid;
    logic                  frame_ready;
    frame_t                frame;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;

    // model state
    logic [FSUM_W-1:0]          left_hist [WIN_LEN];
    logic [FSUM_W-1:0]          right_hist [WIN_LEN];
    logic [21:0]                left_total;
    logic [21:0]                right_total;
    int                         hist_count;
    int                         hist_pos;
    logic signed [COORD_W-1:0]  held_x;
    logic signed [COORD_W-1:0]  held_y;
    logic signed [OFFSET_W-1:0] offset_val;
    logic [MASS_W-1:0]          mass_val;

    result_t   expected_results [$];
    stim_row_t dir_rows [DIRECTED_ROWS];
    int        err_count = 0;
    int        cycle_count = 0;
    bit        idle_en = 1'b1;

    foot_contact_and_center_of_pressure u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // sensor order: back left, back right, front left, front right
    function automatic int sensor_pos(bit axis_y, bit is_right, int idx);
        int p;
        if (!axis_y)
            p = (idx == 0) ? -484 : (idx == 1) ? -474 : 1124;
        else if (!is_right)
            p = (idx == 0) ? 478 : (idx == 1) ? -306 : (idx == 2) ? 478 : -370;
        else
            p = (idx == 0) ? 306 : (idx == 1) ? -478 : (idx == 2) ? 370 : -478;
        return p;
    endfunction

    // nearest, ties away from zero
    function automatic int round_quotient(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (2 * den);
        return (num < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic bit foot_has_contact(logic [21:0] total);
        if (hist_count < WIN_LEN)
            return 1'b0;
        return longint'(total) + longint'(offset_val) * WIN_LEN >=
               longint'(mass_val) * WIN_LEN;
    endfunction

    function automatic bit update_center(logic [63:0] loads, bit is_right);
        longint sx;
        longint sy;
        longint sum;
        longint ld;
        sx = 0;
        sy = 0;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            ld = longint'(loads[63-16*i -: 16]);
            sx += longint'(sensor_pos(1'b0, is_right, i)) * ld;
            sy += longint'(sensor_pos(1'b1, is_right, i)) * ld;
            sum += ld;
        end
        if (sum == 0)
            return 1'b0;
        held_x = COORD_W'(round_quotient(sx, sum));
        held_y = COORD_W'(round_quotient(sy, sum));
        return 1'b1;
    endfunction

    function automatic result_t predict_foot_state(frame_t f);
        logic [FSUM_W-1:0] ls;
        logic [FSUM_W-1:0] rs;
        bit                lc;
        bit                rc;
        bit                upd;
        result_t           r;
        ls = f.left_back_left + f.left_back_right + f.left_front_left
             + f.left_front_right;
        rs = f.right_back_left + f.right_back_right + f.right_front_left
             + f.right_front_right;
        left_total = left_total - left_hist[hist_pos] + ls;
        right_total = right_total - right_hist[hist_pos] + rs;
        left_hist[hist_pos] = ls;
        right_hist[hist_pos] = rs;
        hist_pos = (hist_pos + 1) % WIN_LEN;
        if (hist_count < WIN_LEN)
            hist_count++;
        lc = foot_has_contact(left_total);
        rc = foot_has_contact(right_total);
        upd = 1'b0;
        if (lc && !rc)
            upd = update_center(f[127:64], 1'b0);
        else if (!lc && rc)
            upd = update_center(f[63:0], 1'b1);
        r.left_contact = lc;
        r.right_contact = rc;
        r.pressure_x = held_x;
        r.pressure_y = held_y;
        r.pressure_updated = upd;
        return r;
    endfunction

    function automatic logic [63:0] foot_loads(load_kind_t kind, int eff);
        logic [63:0] v;
        int          hi;
        hi = (kind == LOAD_HEAVY) ? eff / 2 : eff / 16;
        if (hi > 65535)
            hi = 65535;
        for (int i = 0; i < 4; i++)
            v[63-16*i -: 16] = 16'($urandom_range(0, hi));
        if (kind == LOAD_NOISE)
        begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0: v = '1;
                1: v = '0;
                default: ;
            endcase
        end
        // stance foot lifted for one frame while its window is still loaded
        if (kind == LOAD_HEAVY && $urandom_range(0, 15) == 0)
            v = '0;
        return v;
    endfunction

    // both registers, back to back, only while nothing is in flight
    task automatic write_settings(int offset, int mass, bit high_bit);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WEIGHT_OFFSET;
        cfg_data <= offset[16:0];
        @(posedge clk);
        cfg_index <= CFG_TOTAL_MASS;
        cfg_data <= {high_bit, mass[15:0]};
        @(posedge clk);
        cfg_write <= 1'b0;
        offset_val = offset[16:0];
        mass_val = mass[15:0];
    endtask

    task automatic send_frame(frame_t f, bit typed, result_t want);
        result_t guess;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame <= f;
        @(posedge clk);
        while (!frame_ready)
            @(posedge clk);
        guess = predict_foot_state(f);
        expected_results.push_back(typed ? want : guess);
    endtask

    task automatic wait_drained();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_en && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending");
                err_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("left_contact", want.left_contact, result.left_contact);
                check_field("right_contact", want.right_contact, result.right_contact);
                check_field("pressure_x", $signed(want.pressure_x),
                            $signed(result.pressure_x));
                check_field("pressure_y", $signed(want.pressure_y),
                            $signed(result.pressure_y));
                check_field("pressure_updated", want.pressure_updated,
                            result.pressure_updated);
            end
        end
    end

    initial
    begin
        int         sent;
        int         run;
        int         eff;
        int         offset;
        int         mass;
        bit         high_bit;
        gait_t      gait;
        load_kind_t lk;
        load_kind_t rk;
        frame_t     f;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_WEIGHT_OFFSET;
        cfg_data <= '0;
        frame_valid <= 1'b0;
        frame <= '0;

        offset_val = '0;
        mass_val = MASS_RESET;
        for (int i = 0; i < WIN_LEN; i++)
        begin
            left_hist[i] = '0;
            right_hist[i] = '0;
        end
        left_total = '0;
        right_total = '0;
        hist_count = 0;
        hist_pos = 0;
        held_x = '0;
        held_y = '0;

        // window not yet full: no contact, center held at the origin
        dir_rows[0] = '{128'h0, 1'b1, QUIET};
        dir_rows[1] = '{{8{16'hFFFF}}, 1'b1, QUIET};
        dir_rows[2] = '{{8{16'h5555}}, 1'b1, QUIET};
        dir_rows[3] = '{{8{16'hAAAA}}, 1'b1, QUIET};
        dir_rows[4] = '{{{4{16'hFFFF}}, {4{16'h0000}}}, 1'b1, QUIET};
        dir_rows[5] = '{{{4{16'h0000}}, {4{16'hFFFF}}}, 1'b1, QUIET};
        for (int k = 0; k < 8; k++)
            dir_rows[6+k] = '{frame_t'(128'hFFFF << (16 * k)), 1'b1, QUIET};
        dir_rows[14] = '{{8{16'h0001}}, 1'b1, QUIET};
        // window full from here on
        dir_rows[15] = '{{{4{16'hFFFF}}, 64'h0}, 1'b0, QUIET};
        dir_rows[16] = '{{32'h0, 32'hFFFF_FFFF, 64'h0}, 1'b0, QUIET};
        dir_rows[17] = '{{16'hFFFF, 48'h0, 64'h0}, 1'b0, QUIET};
        dir_rows[18] = '{128'h0, 1'b0, QUIET};
        dir_rows[19] = '{{16'd1, 16'd2, 16'd3, 16'd0, 64'h0}, 1'b0, QUIET};
        dir_rows[20] = '{{48'h0, 16'hFFFF, 64'h0}, 1'b0, QUIET};
        dir_rows[21] = '{{{4{16'h8000}}, 64'h0}, 1'b0, QUIET};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            high_bit = 1'b0;
            case (ph)
                0:
                begin
                    offset = -65536;
                    mass = 0;
                    high_bit = 1'b1;
                end
                1:
                begin
                    offset = 65535;
                    mass = 65535;
                end
                2:
                begin
                    offset = 0;
                    mass = 65535;
                    high_bit = 1'b1;
                end
                3:
                begin
                    offset = -2000;
                    mass = 3000;
                end
                4:
                begin
                    offset = int'($urandom_range(0, 131071)) - 65536;
                    mass = $urandom_range(0, 65535);
                    high_bit = 1'($urandom_range(0, 1));
                end
                default:
                begin
                    offset = 0;
                    mass = 5335;
                end
            endcase
            write_settings(offset, mass, high_bit);
            idle_en = (ph != PHASES - 1);

            // per-frame foot sum that sits right at the contact threshold
            eff = mass - offset;
            if (eff < 64)
                eff = 64;
            if (eff > 262140)
                eff = 262140;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                gait = gait_t'($urandom_range(0, 4));
                run = $urandom_range(8, 40);
                case (gait)
                    GAIT_LEFT:
                    begin
                        lk = LOAD_HEAVY;
                        rk = LOAD_LIGHT;
                    end
                    GAIT_RIGHT:
                    begin
                        lk = LOAD_LIGHT;
                        rk = LOAD_HEAVY;
                    end
                    GAIT_DOUBLE:
                    begin
                        lk = LOAD_HEAVY;
                        rk = LOAD_HEAVY;
                    end
                    GAIT_SWING:
                    begin
                        lk = LOAD_LIGHT;
                        rk = LOAD_LIGHT;
                    end
                    default:
                    begin
                        lk = LOAD_NOISE;
                        rk = LOAD_NOISE;
                    end
                endcase
                for (int j = 0; j < run && sent < PHASE_ITEMS; j++)
                begin
                    f = {foot_loads(lk, eff), foot_loads(rk, eff)};
                    send_frame(f, 1'b0, QUIET);
                    sent++;
                    // hold the sender off until the block has fully drained
                    if (ph == 3 && sent == 50)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
